// File: src/ffa_pkg.sv
// Shared types and constants for the first-fit heap allocator.
package ffa_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  // The unused command code reads the counters as well.
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;
  localparam logic [2:0] ST_NULL_ADDR = 3'd5;

  localparam logic REG_HEAP_START = 1'b0;
  localparam logic REG_HEAP_END   = 1'b1;

  localparam logic [31:0] HEAP_START_RST = 32'h0060_0000;
  localparam logic [31:0] HEAP_END_RST   = 32'h0080_0000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_TAKE,
    OP_RELEASE,
    OP_MERGE_PREV,
    OP_MERGE_NEXT,
    OP_MERGE_FOLLOW,
    OP_INSERT,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic zero_size;
    logic over_budget;
    logic table_full;
    logic null_addr;
    logic seg_end;
    logic fit;
    logic rec_end;
    logic rec_hit;
    logic pos_found;
    logic prev_adj;
    logic next_adj;
    logic chain_adj;
    logic seg_full;
  } dp_stat_t;

endpackage

// File: src/ffa_req_if.sv
// Request channel: command word into the allocator.
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] request_size;
  logic [31:0] user_address;

  modport source (output valid, command, request_size, user_address, input ready);
  modport sink   (input valid, command, request_size, user_address, output ready);
endinterface

// File: src/ffa_rsp_if.sv
// Response channel: result word out of the allocator.
interface ffa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] granted_address;
  logic [31:0] bytes_in_use;
  logic [4:0]  blocks_in_use;
  logic [31:0] bytes_free;

  modport source (output valid, status, granted_address, bytes_in_use, blocks_in_use,
                  bytes_free, input ready);
  modport sink   (input valid, status, granted_address, bytes_in_use, blocks_in_use,
                  bytes_free, output ready);
endinterface

// File: src/ffa_datapath.sv
// Datapath: free segment table, allocation records, counters and result register.
module ffa_datapath #(
  parameter int unsigned RECORD_SLOTS = 16,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffa_pkg::dp_cmd_t     cmd_i,
  output ffa_pkg::dp_stat_t    stat_o,
  input  logic [1:0]           command_i,
  input  logic [31:0]          request_size_i,
  input  logic [31:0]          user_address_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_sel_i,
  input  logic [31:0]          cfg_data_i,
  output logic [31:0]          heap_start_o,
  output logic [31:0]          heap_end_o,
  output logic [2:0]           status_o,
  output logic [31:0]          granted_address_o,
  output logic [31:0]          bytes_in_use_o,
  output logic [4:0]           blocks_in_use_o,
  output logic [31:0]          bytes_free_o
);
  import ffa_pkg::*;

  localparam int unsigned FREE_SLOTS = RECORD_SLOTS + 1;
  localparam int unsigned IW = $clog2(FREE_SLOTS + 1);
  localparam int unsigned AW = $clog2(FREE_SLOTS);
  localparam int unsigned RW = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int unsigned BW = $clog2(RECORD_SLOTS + 1);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [32:0] SPLIT_MIN = 33'(2 * HEADER_BYTES);
  localparam logic [31:0] HEAP_TOTAL_RST = HEAP_END_RST - HEAP_START_RST - HDR;

  logic [31:0] heap_start_q, heap_end_q, heap_total_q;
  logic [31:0] fs_start_q [FREE_SLOTS];
  logic [31:0] fs_size_q  [FREE_SLOTS];
  logic [31:0] fs_start_d [FREE_SLOTS];
  logic [31:0] fs_size_d  [FREE_SLOTS];
  logic [IW-1:0] fs_count_q, fs_count_d;
  logic [31:0] us_start_q [RECORD_SLOTS];
  logic [31:0] us_size_q  [RECORD_SLOTS];
  logic [RECORD_SLOTS-1:0] us_valid_q, us_valid_d;
  logic [31:0] used_bytes_q, used_bytes_d;
  logic [BW-1:0] used_blocks_q, used_blocks_d;

  logic [1:0]  cmd_q;
  logic [32:0] total_q;
  logic [31:0] blk_q, bsize_q, pv_start_q, pv_size_q, addr_q;
  logic        null_q;
  logic [IW-1:0] idx_q;

  logic [31:0] cur_start, cur_size, rec_start, rec_size, take_size;
  logic [AW-1:0] cur_idx, prv_idx;
  logic [RW-1:0] rec_idx, slot;
  logic        seg_in, split;
  logic [32:0] diff;
  logic [31:0] ns, ne, nt;

  assign cur_idx   = idx_q[AW-1:0];
  assign prv_idx   = AW'(idx_q - IW'(1));
  assign rec_idx   = idx_q[RW-1:0];
  assign seg_in    = idx_q < fs_count_q;
  assign cur_start = fs_start_q[cur_idx];
  assign cur_size  = fs_size_q[cur_idx];
  assign rec_start = us_start_q[rec_idx];
  assign rec_size  = us_size_q[rec_idx];
  assign diff      = {1'b0, cur_size} - total_q;
  assign split     = diff > SPLIT_MIN;
  assign take_size = split ? total_q[31:0] : cur_size;

  // First free record slot.
  always_comb begin
    slot = '0;
    for (int s = RECORD_SLOTS - 1; s >= 0; s--) begin
      if (!us_valid_q[s]) slot = RW'(s);
    end
  end

  always_comb begin
    stat_o.is_alloc    = cmd_q == CMD_ALLOC;
    stat_o.is_free     = cmd_q == CMD_FREE;
    stat_o.zero_size   = total_q == {1'b0, HDR};
    stat_o.over_budget = total_q > {1'b0, heap_total_q - used_bytes_q};
    stat_o.table_full  = &us_valid_q;
    stat_o.null_addr   = null_q;
    stat_o.seg_end     = !seg_in;
    stat_o.fit         = {1'b0, cur_size} >= total_q;
    stat_o.rec_end     = idx_q >= IW'(RECORD_SLOTS);
    stat_o.rec_hit     = (idx_q < IW'(RECORD_SLOTS)) && us_valid_q[rec_idx] &&
                         (rec_start == blk_q);
    stat_o.pos_found   = cur_start >= blk_q;
    stat_o.prev_adj    = (idx_q != '0) &&
                         ({1'b0, pv_start_q} + {1'b0, pv_size_q} == {1'b0, blk_q});
    stat_o.next_adj    = seg_in && ({1'b0, blk_q} + {1'b0, bsize_q} == {1'b0, cur_start});
    stat_o.chain_adj   = seg_in &&
                         ({1'b0, pv_start_q} + {1'b0, pv_size_q} == {1'b0, cur_start});
    stat_o.seg_full    = fs_count_q >= IW'(FREE_SLOTS);
  end

  // Heap size after a register write.
  always_comb begin
    ns = (cfg_sel_i == REG_HEAP_START) ? cfg_data_i : heap_start_q;
    ne = (cfg_sel_i == REG_HEAP_END) ? cfg_data_i : heap_end_q;
    nt = ({1'b0, ne} >= {1'b0, ns} + {1'b0, HDR}) ? (ne - ns - HDR) : '0;
  end

  // Next state of the free table and counters.
  always_comb begin
    fs_start_d    = fs_start_q;
    fs_size_d     = fs_size_q;
    fs_count_d    = fs_count_q;
    us_valid_d    = us_valid_q;
    used_bytes_d  = used_bytes_q;
    used_blocks_d = used_blocks_q;
    case (cmd_i.op)
      OP_TAKE: begin
        us_valid_d[slot] = 1'b1;
        used_bytes_d     = used_bytes_q + take_size;
        used_blocks_d    = used_blocks_q + BW'(1);
        if (split) begin
          fs_start_d[cur_idx] = cur_start + total_q[31:0];
          fs_size_d[cur_idx]  = cur_size - total_q[31:0];
        end else begin
          for (int k = 0; k < FREE_SLOTS - 1; k++) begin
            if (IW'(k) >= idx_q && IW'(k + 1) < fs_count_q) begin
              fs_start_d[k] = fs_start_q[k + 1];
              fs_size_d[k]  = fs_size_q[k + 1];
            end
          end
          fs_count_d = fs_count_q - IW'(1);
        end
      end
      OP_RELEASE: begin
        us_valid_d[rec_idx] = 1'b0;
        used_bytes_d        = used_bytes_q - rec_size;
        if (used_blocks_q != '0) used_blocks_d = used_blocks_q - BW'(1);
      end
      OP_MERGE_PREV: begin
        fs_size_d[prv_idx] = pv_size_q + bsize_q;
      end
      OP_MERGE_NEXT: begin
        fs_size_d[prv_idx] = pv_size_q + cur_size;
        for (int k = 0; k < FREE_SLOTS - 1; k++) begin
          if (IW'(k) >= idx_q && IW'(k + 1) < fs_count_q) begin
            fs_start_d[k] = fs_start_q[k + 1];
            fs_size_d[k]  = fs_size_q[k + 1];
          end
        end
        fs_count_d = fs_count_q - IW'(1);
      end
      OP_MERGE_FOLLOW: begin
        fs_start_d[cur_idx] = blk_q;
        fs_size_d[cur_idx]  = cur_size + bsize_q;
      end
      OP_INSERT: begin
        for (int k = 1; k < FREE_SLOTS; k++) begin
          if (IW'(k) > idx_q && IW'(k) <= fs_count_q) begin
            fs_start_d[k] = fs_start_q[k - 1];
            fs_size_d[k]  = fs_size_q[k - 1];
          end
        end
        fs_start_d[cur_idx] = blk_q;
        fs_size_d[cur_idx]  = bsize_q;
        fs_count_d          = fs_count_q + IW'(1);
      end
      default: begin
      end
    endcase
    // A register write reinitializes the heap.
    if (cfg_we_i) begin
      fs_start_d[0] = ns;
      fs_size_d[0]  = nt;
      fs_count_d    = (nt != '0) ? IW'(1) : '0;
      us_valid_d    = '0;
      used_bytes_d  = '0;
      used_blocks_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_start_q  <= HEAP_START_RST;
      heap_end_q    <= HEAP_END_RST;
      heap_total_q  <= HEAP_TOTAL_RST;
      fs_count_q    <= IW'(1);
      us_valid_q    <= '0;
      used_bytes_q  <= '0;
      used_blocks_q <= '0;
      for (int k = 0; k < FREE_SLOTS; k++) begin
        fs_start_q[k] <= '0;
        fs_size_q[k]  <= '0;
      end
      fs_start_q[0] <= HEAP_START_RST;
      fs_size_q[0]  <= HEAP_TOTAL_RST;
    end else begin
      if (cfg_we_i) begin
        heap_start_q <= ns;
        heap_end_q   <= ne;
        heap_total_q <= nt;
      end
      fs_start_q    <= fs_start_d;
      fs_size_q     <= fs_size_d;
      fs_count_q    <= fs_count_d;
      us_valid_q    <= us_valid_d;
      used_bytes_q  <= used_bytes_d;
      used_blocks_q <= used_blocks_d;
    end
  end

  // Working registers and record payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cmd_q      <= command_i;
        total_q    <= {1'b0, request_size_i} + {1'b0, HDR};
        blk_q      <= user_address_i - HDR;
        null_q     <= user_address_i == '0;
        idx_q      <= '0;
        addr_q     <= '0;
        pv_start_q <= '0;
        pv_size_q  <= '0;
      end
      OP_STEP: begin
        idx_q      <= idx_q + IW'(1);
        pv_start_q <= cur_start;
        pv_size_q  <= cur_size;
      end
      OP_TAKE: begin
        us_start_q[slot] <= cur_start;
        us_size_q[slot]  <= take_size;
        addr_q           <= cur_start + HDR;
      end
      OP_RELEASE: begin
        bsize_q <= rec_size;
        idx_q   <= '0;
      end
      OP_MERGE_PREV: begin
        pv_size_q <= pv_size_q + bsize_q;
      end
      OP_FINISH: begin
        status_o          <= cmd_i.status;
        granted_address_o <= (cmd_i.status == ST_OK) ? addr_q : '0;
        bytes_in_use_o    <= used_bytes_q;
        blocks_in_use_o   <= 5'(used_blocks_q);
        bytes_free_o      <= heap_total_q - used_bytes_q;
      end
      default: begin
      end
    endcase
  end

  assign heap_start_o = heap_start_q;
  assign heap_end_o   = heap_end_q;

endmodule

// File: src/ffa_ctrl.sv
// Controller: sequences the table scans and updates for one command word.
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ffa_pkg::dp_cmd_t  cmd_o,
  input  ffa_pkg::dp_stat_t stat_i
);
  import ffa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_A_SCAN, S_F_REC, S_F_POS, S_F_CHAIN, S_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] st_q, st_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    st_d          = st_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          st_d     = ST_OK;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_alloc) begin
          if (stat_i.zero_size) begin
            st_d = ST_ZERO_SIZE; state_d = S_FINISH;
          end else if (stat_i.over_budget) begin
            st_d = ST_NO_FIT; state_d = S_FINISH;
          end else if (stat_i.table_full) begin
            st_d = ST_TABLE_FULL; state_d = S_FINISH;
          end else begin
            state_d = S_A_SCAN;
          end
        end else if (stat_i.is_free) begin
          if (stat_i.null_addr) begin
            st_d = ST_NULL_ADDR; state_d = S_FINISH;
          end else begin
            state_d = S_F_REC;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_A_SCAN: begin
        if (stat_i.seg_end) begin
          st_d = ST_NO_FIT; state_d = S_FINISH;
        end else if (stat_i.fit) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      S_F_REC: begin
        if (stat_i.rec_end) begin
          st_d = ST_NOT_ALLOC; state_d = S_FINISH;
        end else if (stat_i.rec_hit) begin
          cmd_o.op = OP_RELEASE;
          state_d  = S_F_POS;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      S_F_POS: begin
        if (stat_i.seg_end || stat_i.pos_found) begin
          if (stat_i.prev_adj) begin
            cmd_o.op = OP_MERGE_PREV;
            state_d  = S_F_CHAIN;
          end else begin
            if (stat_i.next_adj) cmd_o.op = OP_MERGE_FOLLOW;
            else if (!stat_i.seg_full) cmd_o.op = OP_INSERT;
            state_d = S_FINISH;
          end
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      S_F_CHAIN: begin
        // The grown segment may now touch the next one as well.
        if (stat_i.chain_adj) cmd_o.op = OP_MERGE_NEXT;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/first_fit_heap_allocator.sv
// First-fit heap allocator over [heap_start, heap_end) with a header per block and an end
// header below heap_end. One result word per request word. An allocate walks the free
// segments; a free walks the records and then the free segments, and either merges the
// block with the previous segment (and then maybe the next one) or the following one,
// or inserts it as a new segment. The free table and the record table are each walked
// one entry per clock. Writing heap_start or heap_end reinitializes the heap as the
// register is stored; both are readable over APB.
module first_fit_heap_allocator #(
  parameter int unsigned RECORD_SLOTS = 16,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffa_req_if.sink     req_i,
  ffa_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffa_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        cfg_we;
  logic [31:0] heap_start, heap_end;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEAP_END) ? heap_end : heap_start;

  ffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ffa_datapath #(
    .RECORD_SLOTS (RECORD_SLOTS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .command_i         (req_i.command),
    .request_size_i    (req_i.request_size),
    .user_address_i    (req_i.user_address),
    .cfg_we_i          (cfg_we),
    .cfg_sel_i         (paddr[2]),
    .cfg_data_i        (pwdata),
    .heap_start_o      (heap_start),
    .heap_end_o        (heap_end),
    .status_o          (rsp_o.status),
    .granted_address_o (rsp_o.granted_address),
    .bytes_in_use_o    (rsp_o.bytes_in_use),
    .blocks_in_use_o   (rsp_o.blocks_in_use),
    .bytes_free_o      (rsp_o.bytes_free)
  );

endmodule
